/* sv/sprite_post_span_clip_defines.svh */
// Assertion macros shared by the sprite post clipper RTL.
`ifndef SPRITE_POST_SPAN_CLIP_DEFINES_SVH
`define SPRITE_POST_SPAN_CLIP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SPSC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spsc: implication check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SPSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spsc: next-cycle check failed");

`endif

/* sv/spsc_pkg.sv */
// Types, widths and codes for the sprite post span clipper.
`default_nettype none
package spsc_pkg;

    localparam int WORD_W   = 16;
    localparam int PIX_W    = 15;
    localparam int SCALE_W  = 10;
    localparam int VIEW_W   = 10;
    localparam int BOUNCE_W = 21;
    localparam int MUL_W    = SCALE_W + PIX_W;
    localparam int POS_W    = 38;
    localparam int ROW_W    = POS_W - 16;
    localparam int CLIP_W   = 10;
    localparam int FRAC_W   = 32;
    localparam int COUNT_W  = 11;

    localparam int RECIP_NUM = 64 * 65536;
    localparam int ISCALE_W  = $clog2(RECIP_NUM) + 1;
    localparam logic [ISCALE_W-1:0] ISCALE_RESET = ISCALE_W'(RECIP_NUM);

    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_SCALE_HEIGHT  = 3'd0;
    localparam logic [IDX_W-1:0] REG_VIEW_HEIGHT   = 3'd1;
    localparam logic [IDX_W-1:0] REG_BOUNCE_ENABLE = 3'd2;
    localparam logic [IDX_W-1:0] REG_BOUNCE_OFFSET = 3'd3;
    localparam logic [IDX_W-1:0] REG_SHADED_MODE   = 3'd4;
    localparam logic [IDX_W-1:0] REG_CLOAKED       = 3'd5;

    localparam logic [1:0] KIND_PLAIN   = 2'd0;
    localparam logic [1:0] KIND_LIT     = 2'd1;
    localparam logic [1:0] KIND_CLOAKED = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] post_end_word;
        logic [WORD_W-1:0] post_source_word;
        logic [WORD_W-1:0] post_start_word;
    } req_t;

    typedef struct packed {
        logic               column_done;
        logic               draw;
        logic [CLIP_W-1:0]  top_row;
        logic [COUNT_W-1:0] row_count;
        logic [FRAC_W-1:0]  texture_fraction;
        logic [WORD_W-1:0]  source_offset;
        logic [1:0]         column_kind;
    } rsp_t;

    typedef struct packed {
        logic [SCALE_W-1:0]         scale_height;
        logic [VIEW_W-1:0]          view_height;
        logic                       bounce_enable;
        logic signed [BOUNCE_W-1:0] bounce_offset;
        logic                       shaded_mode;
        logic                       cloaked;
    } cfg_t;

endpackage
`default_nettype wire

/* sv/spsc_recip.sv */
// Bit-serial restoring divider: inverse scale = 2^22 / scale_height.
`default_nettype none
module spsc_recip (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              load,
    input  wire logic [spsc_pkg::SCALE_W-1:0]      divisor,
    output logic [spsc_pkg::ISCALE_W-1:0]          iscale,
    output logic                                   busy
);
    localparam int CNT_W = $clog2(spsc_pkg::ISCALE_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(spsc_pkg::ISCALE_W - 1);

    logic                              active_reg, active_next;
    logic [CNT_W-1:0]                  cnt_reg, cnt_next;
    logic [spsc_pkg::SCALE_W-1:0]      rem_reg, rem_next;
    logic [spsc_pkg::ISCALE_W-1:0]     quo_reg, quo_next;
    logic [spsc_pkg::ISCALE_W-1:0]     iscale_reg, iscale_next;
    logic [spsc_pkg::SCALE_W:0]        rem_sh;
    logic [spsc_pkg::SCALE_W:0]        rem_sub;
    logic                              qbit;

    // dividend is a single one in its top bit
    assign rem_sh  = {rem_reg, (cnt_reg == LAST)};
    assign rem_sub = rem_sh - {1'b0, divisor};
    assign qbit    = (rem_sh >= {1'b0, divisor});

    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        iscale_next = iscale_reg;
        if (load)
        begin
            active_next = 1'b1;
            cnt_next    = LAST;
            rem_next    = '0;
            quo_next    = '0;
        end
        else if (active_reg)
        begin
            rem_next = qbit ? rem_sub[spsc_pkg::SCALE_W-1:0] : rem_sh[spsc_pkg::SCALE_W-1:0];
            quo_next = {quo_reg[spsc_pkg::ISCALE_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                active_next = 1'b0;
                iscale_next = {quo_reg[spsc_pkg::ISCALE_W-2:0], qbit};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
            iscale_reg <= spsc_pkg::ISCALE_RESET;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
            iscale_reg <= iscale_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign iscale = iscale_reg;
    assign busy   = active_reg;
endmodule
`default_nettype wire

/* sv/spsc_regs.sv */
// APB configuration registers and inverse scale recompute.
`default_nettype none
module spsc_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [spsc_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    output spsc_pkg::cfg_t                         cfg,
    output logic [spsc_pkg::ISCALE_W-1:0]          iscale,
    output logic                                   busy
);
    spsc_pkg::cfg_t              cfg_reg, cfg_next;
    logic [spsc_pkg::IDX_W-1:0]  idx;
    logic                        wr;
    logic                        load_recip;

    assign idx    = paddr[spsc_pkg::ADDR_W-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        cfg_next   = cfg_reg;
        load_recip = 1'b0;
        if (wr)
        begin
            unique case (idx)
                spsc_pkg::REG_SCALE_HEIGHT:
                begin
                    cfg_next.scale_height = pwdata[spsc_pkg::SCALE_W-1:0];
                    load_recip            = 1'b1;
                end
                spsc_pkg::REG_VIEW_HEIGHT:
                    cfg_next.view_height = pwdata[spsc_pkg::VIEW_W-1:0];
                spsc_pkg::REG_BOUNCE_ENABLE:
                    cfg_next.bounce_enable = pwdata[0];
                spsc_pkg::REG_BOUNCE_OFFSET:
                    cfg_next.bounce_offset = $signed(pwdata[spsc_pkg::BOUNCE_W-1:0]);
                spsc_pkg::REG_SHADED_MODE:
                    cfg_next.shaded_mode = pwdata[0];
                spsc_pkg::REG_CLOAKED:
                    cfg_next.cloaked = pwdata[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            spsc_pkg::REG_SCALE_HEIGHT:  prdata = 32'(cfg_reg.scale_height);
            spsc_pkg::REG_VIEW_HEIGHT:   prdata = 32'(cfg_reg.view_height);
            spsc_pkg::REG_BOUNCE_ENABLE: prdata = 32'(cfg_reg.bounce_enable);
            spsc_pkg::REG_BOUNCE_OFFSET: prdata = {11'b0, cfg_reg.bounce_offset};
            spsc_pkg::REG_SHADED_MODE:   prdata = 32'(cfg_reg.shaded_mode);
            spsc_pkg::REG_CLOAKED:       prdata = 32'(cfg_reg.cloaked);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale_height  <= spsc_pkg::SCALE_W'(1);
            cfg_reg.view_height   <= spsc_pkg::VIEW_W'(200);
            cfg_reg.bounce_enable <= 1'b0;
            cfg_reg.bounce_offset <= '0;
            cfg_reg.shaded_mode   <= 1'b0;
            cfg_reg.cloaked       <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    spsc_recip u_recip (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load_recip),
        .divisor (cfg_next.scale_height),
        .iscale  (iscale),
        .busy    (busy)
    );

    assign cfg = cfg_reg;
endmodule
`default_nettype wire

/* sv/spsc_pipe.sv */
// Three-stage post clip datapath: scale multiply, row rounding, clip and fraction.
`default_nettype none
module spsc_pipe (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire spsc_pkg::req_t                    req,
    input  wire spsc_pkg::cfg_t                    cfg,
    input  wire logic [spsc_pkg::ISCALE_W-1:0]     iscale,
    output logic                                   out_valid,
    output spsc_pkg::rsp_t                         rsp
);
`include "sprite_post_span_clip_defines.svh"

    localparam int POS_W = spsc_pkg::POS_W;
    localparam int ROW_W = spsc_pkg::ROW_W;
    localparam int MUL_W = spsc_pkg::MUL_W;

    // stage 1
    logic                              v1_reg;
    logic                              done1_reg, hz1_reg;
    logic [spsc_pkg::WORD_W-1:0]       src1_reg;
    logic [1:0]                        kind1_reg;
    logic signed [POS_W-1:0]           top1_reg;
    logic [MUL_W-1:0]                  hs1_reg, he1_reg;

    logic [spsc_pkg::PIX_W-1:0]        end_pix, start_pix;
    logic signed [spsc_pkg::SCALE_W:0] hdiff;
    logic signed [POS_W-1:0]           hdiff_ext;
    logic signed [spsc_pkg::BOUNCE_W-2:0] half_bounce;
    logic signed [POS_W-1:0]           top_next;
    logic [1:0]                        kind_next;

    // stage 2
    logic                              v2_reg;
    logic                              done2_reg, hz2_reg;
    logic [spsc_pkg::WORD_W-1:0]       src2_reg;
    logic [1:0]                        kind2_reg;
    logic signed [ROW_W-1:0]           yl2_reg, yh2_reg;

    logic signed [POS_W-1:0]           top_scr, bot_scr, top_up, bot_dn;

    // stage 3
    logic                              v3_reg;
    spsc_pkg::rsp_t                    rsp_reg, rsp_next;

    logic signed [ROW_W-1:0]           vh_m1, yh_c, yl_c, yl_neg, span;
    logic                              ok;
    logic [spsc_pkg::ISCALE_W+spsc_pkg::CLIP_W-1:0] frac_full;

    // stage 1: halve words, scale multiplies, sprite top
    assign end_pix     = req.post_end_word[spsc_pkg::WORD_W-1:1];
    assign start_pix   = req.post_start_word[spsc_pkg::WORD_W-1:1];
    assign hdiff       = $signed({1'b0, cfg.view_height}) - $signed({1'b0, cfg.scale_height});
    assign hdiff_ext   = POS_W'(hdiff);
    assign half_bounce = cfg.bounce_offset[spsc_pkg::BOUNCE_W-1:1];
    assign top_next    = (hdiff_ext <<< 15)
                       + (cfg.bounce_enable ? POS_W'(half_bounce) : '0);
    assign kind_next   = cfg.shaded_mode ? (cfg.cloaked ? spsc_pkg::KIND_CLOAKED
                                                        : spsc_pkg::KIND_LIT)
                                         : spsc_pkg::KIND_PLAIN;

    always_ff @(posedge clk)
    begin
        done1_reg <= (end_pix == '0);
        hz1_reg   <= (cfg.scale_height == '0);
        src1_reg  <= req.post_source_word + spsc_pkg::WORD_W'(start_pix);
        kind1_reg <= kind_next;
        top1_reg  <= top_next;
        hs1_reg   <= MUL_W'(cfg.scale_height) * MUL_W'(start_pix);
        he1_reg   <= MUL_W'(cfg.scale_height) * MUL_W'(end_pix);
    end

    // stage 2: screen positions in 22.16, round to rows
    assign top_scr = top1_reg + $signed({3'b0, hs1_reg, 10'b0});
    assign bot_scr = top1_reg + $signed({3'b0, he1_reg, 10'b0});
    assign top_up  = top_scr + POS_W'(65535);
    assign bot_dn  = bot_scr - POS_W'(1);

    always_ff @(posedge clk)
    begin
        done2_reg <= done1_reg;
        hz2_reg   <= hz1_reg;
        src2_reg  <= src1_reg;
        kind2_reg <= kind1_reg;
        yl2_reg   <= top_up[POS_W-1:16];
        yh2_reg   <= bot_dn[POS_W-1:16];
    end

    // stage 3: clip to the view, fraction for rows lost off the top
    assign vh_m1     = $signed(ROW_W'(cfg.view_height)) - ROW_W'(1);
    assign yh_c      = (yh2_reg > vh_m1) ? vh_m1 : yh2_reg;
    assign yl_c      = yl2_reg[ROW_W-1] ? '0 : yl2_reg;
    assign yl_neg    = -yl2_reg;
    assign span      = yh_c - yl_c + ROW_W'(1);
    assign ok        = !hz2_reg && (yl_c <= yh_c);
    // top never sits more than a few hundred rows above the view
    assign frac_full = iscale * (yl2_reg[ROW_W-1] ? yl_neg[spsc_pkg::CLIP_W-1:0]
                                                  : spsc_pkg::CLIP_W'(0));

    always_comb
    begin
        rsp_next = '0;
        if (done2_reg)
        begin
            rsp_next.column_done = 1'b1;
        end
        else
        begin
            rsp_next.source_offset = src2_reg;
            rsp_next.column_kind   = kind2_reg;
            if (ok)
            begin
                rsp_next.draw             = 1'b1;
                rsp_next.top_row          = yl_c[spsc_pkg::CLIP_W-1:0];
                rsp_next.row_count        = span[spsc_pkg::COUNT_W-1:0];
                rsp_next.texture_fraction = frac_full[spsc_pkg::FRAC_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign rsp       = rsp_reg;

    `SPSC_ASSERT_NEXT(a_item_reaches_output, v2_reg, v3_reg)
    `SPSC_ASSERT_IMPL(a_draw_nonempty, v3_reg && rsp_reg.draw, rsp_reg.row_count != '0)
    `SPSC_ASSERT_IMPL(a_done_no_draw, v3_reg && rsp_reg.column_done, !rsp_reg.draw && rsp_reg.source_offset == '0)
    `SPSC_ASSERT_IMPL(a_span_in_view, v3_reg && rsp_reg.draw, ({1'b0, rsp_reg.top_row} + rsp_reg.row_count) <= {1'b0, cfg.view_height})
endmodule
`default_nettype wire

/* sv/sprite_post_span_clip.sv */
// An accepted request passes the stage 1, 2 and 3 registers and is then strobed on result_valid.
// One request per cycle when not busy; the receiver cannot stall the three-stage pipeline.
// Writing scale_height reruns a one-bit-per-cycle divider for the inverse scale;
// busy is high while the divider runs after that write, otherwise low.
// Reset (rst_n, async low) clears pipeline valids and loads register reset values.
`default_nettype none
module sprite_post_span_clip (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [spsc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  wire logic                          start,
    output logic                               busy,
    input  wire spsc_pkg::req_t                req,
    output logic                               result_valid,
    output spsc_pkg::rsp_t                     result
);
    spsc_pkg::cfg_t                  cfg;
    logic [spsc_pkg::ISCALE_W-1:0]   iscale;
    logic                            recip_busy;

    spsc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .iscale  (iscale),
        .busy    (recip_busy)
    );

    assign busy = recip_busy;

    spsc_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !recip_busy),
        .req       (req),
        .cfg       (cfg),
        .iscale    (iscale),
        .out_valid (result_valid),
        .rsp       (result)
    );
endmodule
`default_nettype wire
